[hw/rtl/fac_pkg.sv]
package fac_pkg;

    localparam int MAX_LINES = 16;
    localparam int LINE_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int ADDR_W    = 30;
    localparam int OFS_W     = 4;
    localparam int RANK_W    = LINE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES  = 2'd2;

    // replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // broadcast update to every line cell
    typedef struct packed {
        logic              touch;
        logic              fill;
        logic [LINE_W-1:0] line;
        logic              old_valid;
        logic [RANK_W-1:0] old_rank;
        logic [ADDR_W-1:0] tag;
    } fac_upd_t;

    // running victim candidate handed along the cell row
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [LINE_W-1:0] idx;
    } fac_best_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOK   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_DONE   = 5'b10000
    } fac_state_t;

endpackage

[hw/rtl/fac_in_if.sv]
interface fac_in_if;
    import fac_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] word_address;

    modport source (output valid, output word_address, input ready);
    modport sink   (input valid, input word_address, output ready);
endinterface

[hw/rtl/fac_out_if.sv]
interface fac_out_if;
    import fac_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [LINE_W-1:0] line_index;

    modport source (output valid, output hit, output line_index, input ready);
    modport sink   (input valid, input hit, input line_index, output ready);
endinterface

[hw/rtl/fac_cell.sv]
module fac_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fac_pkg::LINE_W-1:0]    cell_idx,
    input  logic                          active,
    input  logic [fac_pkg::ADDR_W-1:0]    cmp_tag,
    input  fac_pkg::fac_upd_t             upd,
    input  fac_pkg::fac_best_t            best_in,
    output fac_pkg::fac_best_t            best_out,
    output logic                          match,
    output logic                          valid,
    output logic [fac_pkg::RANK_W-1:0]    rank
);
    import fac_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] tag_reg;
    logic [ADDR_W-1:0] tag_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    fac_best_t         best_reg;
    fac_best_t         best_next;
    logic              self_sel;

    assign self_sel = (upd.line == cell_idx);

    // tag compare for this line
    assign match = valid_reg && active && (tag_reg == cmp_tag);
    assign valid = valid_reg;
    assign rank  = rank_reg;

    // fill and recency update
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        rank_next  = rank_reg;
        if (upd.touch || upd.fill)
        begin
            if (self_sel)
            begin
                rank_next = '0;
            end
            else if (active && valid_reg && (!upd.old_valid || rank_reg < upd.old_rank))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
        if (upd.fill && self_sel)
        begin
            tag_next   = upd.tag;
            valid_next = 1'b1;
        end
    end

    // oldest line so far, lowest index wins ties
    always_comb
    begin
        if (rank_reg > best_in.rank)
        begin
            best_next.rank = rank_reg;
            best_next.idx  = cell_idx;
        end
        else
        begin
            best_next = best_in;
        end
    end

    assign best_out = best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        rank_reg <= rank_next;
        best_reg <= best_next;
    end

endmodule

[hw/rtl/fully_assoc_cache_fifo_lru.sv]
// Fully associative tag directory of 16 lines with FIFO or LRU replacement.
// Each request carries a word address; the address is shifted right by the
// block offset and compared against every valid active line in parallel.
// One response per request gives the hit flag and the line that hit or was
// filled. After a request is accepted it passes through the tag compare,
// the decision and the result stage, and its response is then offered from
// the output register. An LRU miss with every active line full adds a scan
// over every active line (lines_reg clamped to 1..16) while the candidate
// victim ripples one cell per cycle down the row of line cells. A new
// request is taken once the previous result has moved into the output
// register, while its response may still be waiting there; a response held
// by the sink stalls the next request. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module fully_assoc_cache_fifo_lru (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fac_pkg::CFG_DAT_W-1:0]    cfg_data,
    fac_in_if.sink                           req,
    fac_out_if.source                        rsp
);
    import fac_pkg::*;

    // configuration
    logic              policy_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [CNT_W-1:0]  lines_reg;
    logic [CNT_W-1:0]  n_act;

    // control
    fac_state_t        state_reg;
    fac_state_t        state_next;
    logic [CNT_W-1:0]  fp_reg;
    logic [CNT_W-1:0]  fp_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W:0]    fp_inc;

    // request tag and lookup results
    logic [ADDR_W-1:0] tag_reg;
    logic              hit_reg;
    logic [LINE_W-1:0] hit_line_reg;
    logic              inv_found_reg;
    logic [LINE_W-1:0] inv_line_reg;
    logic              hit_any;
    logic [LINE_W-1:0] hit_idx;
    logic              inv_any;
    logic [LINE_W-1:0] inv_idx;

    // result stage and output register
    logic              res_hit_reg;
    logic              res_hit_next;
    logic [LINE_W-1:0] res_line_reg;
    logic [LINE_W-1:0] res_line_next;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic              out_load;

    // cell row
    logic [MAX_LINES-1:0] active_vec;
    logic [MAX_LINES-1:0] match_vec;
    logic [MAX_LINES-1:0] valid_vec;
    logic [RANK_W-1:0]    rank_arr   [MAX_LINES];
    fac_best_t            best_chain [MAX_LINES+1];
    fac_upd_t             upd;

    // active line count clamped to 1..MAX_LINES
    always_comb
    begin
        if (lines_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (lines_reg > CNT_W'(MAX_LINES))
        begin
            n_act = CNT_W'(MAX_LINES);
        end
        else
        begin
            n_act = lines_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            offset_reg <= OFS_W'(2);
            lines_reg  <= CNT_W'(MAX_LINES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_data[0];
                CFG_OFFSET: offset_reg <= cfg_data[OFS_W-1:0];
                CFG_LINES:  lines_reg  <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // line cells
    assign best_chain[0] = '{rank: '0, idx: '0};

    genvar g;
    generate
        for (g = 0; g < MAX_LINES; g++)
        begin : g_cell
            assign active_vec[g] = (CNT_W'(g) < n_act);

            fac_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (LINE_W'(g)),
                .active   (active_vec[g]),
                .cmp_tag  (tag_reg),
                .upd      (upd),
                .best_in  (best_chain[g]),
                .best_out (best_chain[g+1]),
                .match    (match_vec[g]),
                .valid    (valid_vec[g]),
                .rank     (rank_arr[g])
            );
        end
    endgenerate

    // lowest matching line and lowest empty active line
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        inv_any = 1'b0;
        inv_idx = '0;
        for (int i = MAX_LINES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = LINE_W'(i);
            end
            if (active_vec[i] && !valid_vec[i])
            begin
                inv_any = 1'b1;
                inv_idx = LINE_W'(i);
            end
        end
    end

    // round-robin pointer advance
    assign fp_inc = {1'b0, fp_reg} + 1'b1;

    // sequencer and update command
    always_comb
    begin
        state_next    = state_reg;
        fp_next       = fp_reg;
        cnt_next      = cnt_reg;
        res_hit_next  = res_hit_reg;
        res_line_next = res_line_reg;
        out_load      = 1'b0;
        upd.touch     = 1'b0;
        upd.fill      = 1'b0;
        upd.line      = '0;
        upd.tag       = tag_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                res_hit_next = hit_reg;
                state_next   = ST_DONE;
                if (policy_reg == POLICY_FIFO)
                begin
                    if (hit_reg)
                    begin
                        res_line_next = hit_line_reg;
                    end
                    else
                    begin
                        if (fp_inc < {1'b0, n_act})
                        begin
                            fp_next = fp_inc[CNT_W-1:0];
                        end
                        else
                        begin
                            fp_next = '0;
                        end
                        res_line_next = fp_next[LINE_W-1:0];
                        upd.fill      = 1'b1;
                        upd.line      = fp_next[LINE_W-1:0];
                    end
                end
                else if (hit_reg)
                begin
                    res_line_next = hit_line_reg;
                    upd.touch     = 1'b1;
                    upd.line      = hit_line_reg;
                end
                else if (inv_found_reg)
                begin
                    res_line_next = inv_line_reg;
                    fp_next       = CNT_W'(inv_line_reg) + 1'b1;
                    upd.fill      = 1'b1;
                    upd.line      = inv_line_reg;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == n_act - 1'b1)
                begin
                    res_line_next = best_chain[n_act].idx;
                    upd.fill      = 1'b1;
                    upd.line      = best_chain[n_act].idx;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        upd.old_valid = valid_vec[upd.line];
        upd.old_rank  = rank_arr[upd.line];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fp_reg    <= fp_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            tag_reg <= req.word_address >> offset_reg;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg       <= hit_any;
            hit_line_reg  <= hit_idx;
            inv_found_reg <= inv_any;
            inv_line_reg  <= inv_idx;
        end
        res_hit_reg  <= res_hit_next;
        res_line_reg <= res_line_next;
        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_line_reg <= res_line_reg;
        end
    end

    // ports
    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.line_index = out_line_reg;

    // a reported hit names a valid line
    a_hit_line_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_hit_reg) |-> valid_vec[res_line_reg])
        else $error("hit response names an empty line");

    // a filled line is valid and most recent afterwards
    a_fill_most_recent: assert property (@(posedge clk) disable iff (!rst_n)
        upd.fill |=> (valid_vec[$past(upd.line)] && rank_arr[$past(upd.line)] == '0))
        else $error("filled line not valid or not most recent");

    // victim scan never runs past the active lines
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg < n_act))
        else $error("victim scan count out of range");

    // the response line lies within the active lines
    a_line_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (CNT_W'(res_line_reg) < n_act))
        else $error("response line outside active lines");

endmodule

[test/fully_assoc_cache_fifo_lru_tb.sv]
`timescale 1ns / 100ps

module fully_assoc_cache_fifo_lru_tb;
    import fac_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYC   = 8;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 80;
    localparam int CALM_PHASES  = 2;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line;
    } lookup_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    fac_in_if  req_if ();
    fac_out_if rsp_if ();

    fully_assoc_cache_fifo_lru u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // shadow of the tag directory and its registers
    logic [ADDR_W-1:0] dir_tag   [MAX_LINES];
    logic              dir_valid [MAX_LINES];
    logic [7:0]        dir_rank  [MAX_LINES];
    logic [4:0]        dir_fill_ptr;
    logic              cfg_policy_m;
    logic [OFS_W-1:0]  cfg_ofs_m;
    logic [CNT_W-1:0]  cfg_lines_m;

    // request addresses waiting for the driver, lookups waiting for a response
    logic [ADDR_W-1:0] addr_backlog [$];
    lookup_t           pending_lookups [$];
    logic [ADDR_W-1:0] tag_pool [$];

    int  queued_total   = 0;
    int  accepted_total = 0;
    int  error_count    = 0;
    int  quiet_cycles   = 0;
    int  send_hold      = 0;
    int  stall_left     = 0;
    bit  calm_tail      = 1'b0;
    bit  req_taken      = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int active_lines_m();
        int n;
        n = int'(cfg_lines_m);
        if (n == 0) n = 1;
        if (n > MAX_LINES) n = MAX_LINES;
        return n;
    endfunction

    // make a line most recent, aging every more recent valid active line
    function automatic void promote_line(int l, int n);
        logic       old_valid;
        logic [7:0] old_rank;
        old_valid = dir_valid[l];
        old_rank  = dir_rank[l];
        for (int i = 0; i < n; i++)
        begin
            if (i != l && dir_valid[i] && (!old_valid || dir_rank[i] < old_rank))
                dir_rank[i] = dir_rank[i] + 8'd1;
        end
        dir_rank[l] = 8'd0;
    endfunction

    function automatic void fill_line(int l, logic [ADDR_W-1:0] tag, int n);
        promote_line(l, n);
        dir_tag[l]   = tag;
        dir_valid[l] = 1'b1;
    endfunction

    // lookup and replacement for one access
    function automatic lookup_t predict_lookup(logic [ADDR_W-1:0] addr);
        lookup_t           res;
        int                n;
        int                victim;
        logic [ADDR_W-1:0] tag;
        logic              found;
        logic              empty;
        logic [7:0]        best;
        n      = active_lines_m();
        tag    = addr >> cfg_ofs_m;
        found  = 1'b0;
        victim = 0;
        // lowest matching line wins on duplicate tags
        for (int i = 0; i < n; i++)
        begin
            if (!found && dir_valid[i] && dir_tag[i] == tag)
            begin
                found  = 1'b1;
                victim = i;
            end
        end
        if (cfg_policy_m == POLICY_FIFO)
        begin
            if (!found)
            begin
                if (int'(dir_fill_ptr) + 1 < n)
                    dir_fill_ptr = dir_fill_ptr + 5'd1;
                else
                    dir_fill_ptr = 5'd0;
                victim = int'(dir_fill_ptr);
                fill_line(victim, tag, n);
            end
        end
        else if (found)
        begin
            promote_line(victim, n);
        end
        else
        begin
            empty = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (!empty && !dir_valid[i])
                begin
                    empty  = 1'b1;
                    victim = i;
                end
            end
            if (empty)
            begin
                dir_fill_ptr = 5'(victim + 1);
            end
            else
            begin
                // oldest line, lowest index on ties
                best   = 8'd0;
                victim = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (dir_rank[i] > best)
                    begin
                        best   = dir_rank[i];
                        victim = i;
                    end
                end
            end
            fill_line(victim, tag, n);
        end
        res.hit  = found;
        res.line = LINE_W'(victim);
        return res;
    endfunction

    // random access address, mostly from the phase's working set of blocks
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] t;
        logic [ADDR_W-1:0] low_mask;
        if ($urandom_range(0, 7) == 0 || tag_pool.size() == 0)
            return ADDR_W'($urandom);
        t        = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
        low_mask = (ADDR_W'(1) << cfg_ofs_m) - ADDR_W'(1);
        return (t << cfg_ofs_m) | (ADDR_W'($urandom) & low_mask);
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        if (error_count < MAX_REPORTS)
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
        error_count++;
    endtask

    // register write, tracked by the shadow copy
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_POLICY)
            cfg_policy_m = data[0];
        else if (idx == CFG_OFFSET)
            cfg_ofs_m = data[OFS_W-1:0];
        else if (idx == CFG_LINES)
            cfg_lines_m = data[CNT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_address(logic [ADDR_W-1:0] a);
        addr_backlog = {addr_backlog, a};
        queued_total++;
    endtask

    // hold off until every request is answered and the block has settled
    task automatic drain_wait();
        while (!(accepted_total == queued_total && pending_lookups.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_if.valid || req_taken)
            begin
                if (send_hold > 0)
                begin
                    send_hold    <= send_hold - 1;
                    req_if.valid <= 1'b0;
                end
                else if (addr_backlog.size() > 0)
                begin
                    req_if.valid        <= 1'b1;
                    req_if.word_address <= addr_backlog.pop_front();
                    if (!calm_tail && $urandom_range(0, 9) == 0)
                        send_hold <= $urandom_range(1, 13);
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 9) == 0)
                    stall_left <= $urandom_range(1, 13);
            end
        end
    end

    // monitor, predictor hook and watchdog
    always @(posedge clk)
    begin
        lookup_t want;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            req_taken <= req_if.valid && req_if.ready;
            // check response against oldest lookup
            if (rsp_if.valid && rsp_if.ready)
            begin
                moved = 1'b1;
                if (pending_lookups.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected response at %0t: hit %0d line %0d",
                                 $realtime, rsp_if.hit, rsp_if.line_index);
                    error_count++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (rsp_if.hit !== want.hit)
                        report_mismatch("hit", want.hit, rsp_if.hit);
                    if (rsp_if.line_index !== want.line)
                        report_mismatch("line_index", want.line, rsp_if.line_index);
                end
            end
            // accepted request
            if (req_if.valid && req_if.ready)
            begin
                moved = 1'b1;
                want = predict_lookup(req_if.word_address);
                pending_lookups = {pending_lookups, want};
                accepted_total++;
            end
            if (moved)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("fully_assoc_cache_fifo_lru_tb NOT OK");
                    $finish;
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int n;
        int sel;
        logic [CFG_DAT_W-1:0] ofs_pick;
        logic [CFG_DAT_W-1:0] lines_pick;
        req_if.valid        = 1'b0;
        req_if.word_address = '0;
        rsp_if.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_POLICY;
        cfg_data            = '0;
        rst_n               = 1'b0;
        // shadow state after reset
        for (int i = 0; i < MAX_LINES; i++)
        begin
            dir_tag[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_rank[i]  = 8'd0;
        end
        dir_fill_ptr = 5'd0;
        cfg_policy_m = POLICY_FIFO;
        cfg_ofs_m    = OFS_W'(2);
        cfg_lines_m  = CNT_W'(16);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: address extremes, hits within one block
        @(posedge clk);
        push_address(30'h0000_0000);
        push_address(30'h0000_0003);
        push_address(30'h3FFF_FFFF);
        push_address(30'h3FFF_FFFC);
        push_address(30'h0000_0004);
        push_address(30'h0000_0000);
        drain_wait();

        // lru with three lines: fill the empty line, refresh, evict oldest
        write_reg(CFG_POLICY, CFG_DAT_W'(POLICY_LRU));
        write_reg(CFG_OFFSET, 5'd0);
        write_reg(CFG_LINES, 5'd3);
        @(posedge clk);
        push_address(30'd20);
        push_address(30'd0);
        push_address(30'd21);
        push_address(30'd20);
        push_address(30'd22);
        push_address(30'd21);
        push_address(30'd23);
        push_address(30'd22);
        drain_wait();

        // zero lines acts as one, widest offset, pointer beyond last line
        write_reg(CFG_POLICY, CFG_DAT_W'(POLICY_FIFO));
        write_reg(CFG_OFFSET, 5'd15);
        write_reg(CFG_LINES, 5'd0);
        @(posedge clk);
        push_address(30'h3FFF_FFFF);
        push_address(30'h3FFF_8000);
        push_address(30'h0000_7FFF);
        push_address(30'h3FFF_8000);
        drain_wait();

        // count above the line total acts as all lines, old tags come back
        write_reg(CFG_LINES, 5'd31);
        write_reg(CFG_OFFSET, 5'd8);
        @(posedge clk);
        push_address(30'h0000_0000);
        push_address(30'h3FFF_FFFF);
        push_address(30'h0000_00FF);
        push_address(30'h0000_0100);
        drain_wait();

        // random phases, each with its own settings and working set
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            sel = $urandom_range(0, 3);
            if (sel == 0)
                ofs_pick = 5'd0;
            else if (sel == 1)
                ofs_pick = 5'd15;
            else
                ofs_pick = CFG_DAT_W'($urandom_range(0, 15));
            sel = $urandom_range(0, 6);
            if (sel == 0)
                lines_pick = 5'd1;
            else if (sel == 1)
                lines_pick = 5'd16;
            else if (sel == 2)
                lines_pick = 5'd0;
            else if (sel == 3)
                lines_pick = 5'd31;
            else if (sel == 4)
                lines_pick = CFG_DAT_W'($urandom_range(17, 31));
            else
                lines_pick = CFG_DAT_W'($urandom_range(1, 16));
            write_reg(CFG_LINES, lines_pick);
            write_reg(CFG_OFFSET, ofs_pick);
            write_reg(CFG_POLICY, CFG_DAT_W'($urandom_range(0, 1)));
            if (ph >= RAND_PHASES - CALM_PHASES)
                calm_tail = 1'b1;

            // working set a little smaller or larger than the active lines
            n = active_lines_m();
            tag_pool.delete();
            for (int k = 0; k < $urandom_range(1, n + 4); k++)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    tag_pool = {tag_pool, ADDR_W'(0)};
                else if (sel == 1)
                    tag_pool = {tag_pool, ADDR_W'({ADDR_W{1'b1}} >> cfg_ofs_m)};
                else
                    tag_pool = {tag_pool, ADDR_W'(ADDR_W'($urandom) >> cfg_ofs_m)};
            end
            @(posedge clk);
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_address(pick_address());
            drain_wait();
        end

        repeat (16) @(negedge clk);
        if (error_count == 0 && pending_lookups.size() == 0)
        begin
            $display("fully_assoc_cache_fifo_lru_tb OK");
        end
        else
        begin
            $display("fully_assoc_cache_fifo_lru_tb NOT OK");
        end
        $finish;
    end

endmodule
